@@ rtl/dbcs_pkg.sv @@
// Shared types and constants for the double-byte charset table converter.
// No dependencies; used by the interfaces, the table memory and the top level.
package dbcs_pkg;

    localparam logic [7:0] QMARK = 8'h3f;

    // Work held between the table read and the output register
    localparam logic [1:0] KIND_PAIR  = 2'd0;  // lead plus nonzero trail, table lookup
    localparam logic [1:0] KIND_ZTRL  = 2'd1;  // lead followed by zero trail
    localparam logic [1:0] KIND_END   = 2'd2;  // zero byte with no lead held
    localparam logic [1:0] KIND_ASCII = 2'd3;  // byte below 128 with no lead held

    localparam logic [1:0] DIR_UNI_FIRST = 2'd2;  // directions from here on give UTF-16LE

    typedef struct packed {
        logic        mode;
        logic [7:0]  in_byte;
        logic [1:0]  table_select;
        logic [6:0]  load_lead;
        logic [7:0]  load_trail;
        logic [15:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
        logic       last;
    } t_out_item;

    // One table access per cycle: a write from a load item or a read for a pair
    typedef struct packed {
        logic        we;
        logic        re;
        logic [1:0]  tsel;
        logic [6:0]  row;
        logic [7:0]  col;
        logic [15:0] wdata;
    } t_tbl_req;

endpackage

@@ rtl/dbcs_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on dbcs_pkg for the payload types.
interface dbcs_in_if;
    import dbcs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbcs_out_if;
    import dbcs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dbcs_tbl.sv @@
// Code table memory: one synchronous single-port RAM with registered read data,
// plus the clearing sweep after reset. Depends on dbcs_pkg.
module dbcs_tbl #(
    parameter int TW = 2,
    parameter int RW = 7,
    parameter int CW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dbcs_pkg::t_tbl_req i_req,
    output logic [15:0]       o_rd_data,
    output logic              o_clr_done
);
    import dbcs_pkg::*;

    localparam int AW    = TW + RW + CW;
    localparam int DEPTH = 2 ** AW;

    logic [15:0]   mem [DEPTH];
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_clr_done, n_clr_done;
    logic [15:0]   r_rd_data;
    logic [AW-1:0] acc_addr;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          wr_en;

    assign acc_addr = {i_req.tsel[TW-1:0], i_req.row[RW-1:0], i_req.col[CW-1:0]};

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clr_done = r_clr_done;
        if (!r_clr_done) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                n_clr_done = 1'b1;
            end
        end
    end

    assign wr_en   = !r_clr_done || i_req.we;
    assign wr_addr = r_clr_done ? acc_addr : r_clr_addr;
    assign wr_data = r_clr_done ? i_req.wdata : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_clr_done <= n_clr_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.re) begin
            r_rd_data <= mem[acc_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_done = r_clr_done;

endmodule

@@ rtl/dbcs_table_charset_converter.sv @@
// Top level of the Big5 / GBK / UTF-16LE table converter.
// Depends on dbcs_pkg, dbcs_if (dbcs_in_if, dbcs_out_if) and dbcs_tbl.
//
//  port       dir  kind          carries
//  i_in       in   valid/ready   load items and source bytes (t_in_item)
//  o_out      out  valid/ready   converted bytes (t_out_item)
//  i_cfg_*    in   write only    direction register
//
// A byte giving two results holds the output register until both have been taken, one
// giving a single result until that one is taken; load items and lead bytes give no result.
// A converted byte passes the read stage (table read), then the output register; the read
// stage can take another byte while the output register still holds results. Reset starts a
// clearing sweep over all 2**(TW+RW+CW) table entries (131072 at the defaults), during which no item is taken.
// Output stalls back up through the read stage to i_in.ready.
module dbcs_table_charset_converter #(
    parameter int LEAD_ROWS  = 128,
    parameter int TRAIL_COLS = 256,
    parameter int NUM_TABLES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_wdata,
    dbcs_in_if.sink          i_in,
    dbcs_out_if.source       o_out
);
    import dbcs_pkg::*;

    localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int RW = (LEAD_ROWS > 1)  ? $clog2(LEAD_ROWS)  : 1;
    localparam int CW = (TRAIL_COLS > 1) ? $clog2(TRAIL_COLS) : 1;

    logic [1:0]  r_direction;
    logic        r_lead_pending, n_lead_pending;
    logic [6:0]  r_held_lead;

    // read stage
    logic        r_b_valid, n_b_valid;
    logic [1:0]  r_b_kind;
    logic [7:0]  r_b_byte;
    logic        r_b_uni;
    logic        r_b_oor;

    // output register
    logic        r_o_valid, n_o_valid;
    logic        r_o_sel, n_o_sel;
    logic [7:0]  r_o_b0, r_o_b1;
    logic        r_o_two;
    logic        r_o_eos;

    logic        clr_done;
    logic [15:0] rd_data;
    t_tbl_req    tbl_req;

    logic        in_acc, conv, load, load_ok;
    logic        is_pair, is_ztrl, is_end, is_ascii, is_lead, b_load;
    logic [1:0]  b_kind;
    logic        rd_oor;
    logic        o_xfer, o_done, o_free, b_move;

    logic [15:0] code;
    logic [7:0]  res_b0, res_b1;
    logic        res_two, res_eos;

    t_in_item    in_d;
    assign in_d = i_in.data;

    // handshakes
    assign o_xfer = r_o_valid && o_out.ready;
    assign o_done = o_xfer && (!r_o_two || r_o_sel);
    assign o_free = !r_o_valid || o_done;
    assign b_move = r_b_valid && o_free;

    assign i_in.ready = clr_done && (!r_b_valid || b_move);
    assign in_acc     = i_in.valid && i_in.ready;
    assign conv       = in_acc && in_d.mode;
    assign load       = in_acc && !in_d.mode;

    assign is_pair  = conv && r_lead_pending && (in_d.in_byte != 8'd0);
    assign is_ztrl  = conv && r_lead_pending && (in_d.in_byte == 8'd0);
    assign is_end   = conv && !r_lead_pending && (in_d.in_byte == 8'd0);
    assign is_ascii = conv && !r_lead_pending && (in_d.in_byte != 8'd0) && !in_d.in_byte[7];
    assign is_lead  = conv && !r_lead_pending && in_d.in_byte[7];
    assign b_load   = is_pair || is_ztrl || is_end || is_ascii;

    always_comb begin
        if (is_pair) begin
            b_kind = KIND_PAIR;
        end else if (is_ztrl) begin
            b_kind = KIND_ZTRL;
        end else if (is_end) begin
            b_kind = KIND_END;
        end else begin
            b_kind = KIND_ASCII;
        end
    end

    assign load_ok = (int'(in_d.table_select) < NUM_TABLES)
                  && (int'(in_d.load_lead) < LEAD_ROWS)
                  && (int'(in_d.load_trail) < TRAIL_COLS);

    // entries outside the configured tables read as unmapped
    assign rd_oor = (int'(r_direction) >= NUM_TABLES)
                 || (int'(r_held_lead) >= LEAD_ROWS)
                 || (int'(in_d.in_byte) >= TRAIL_COLS);

    always_comb begin
        tbl_req.we    = load && load_ok;
        tbl_req.re    = is_pair;
        tbl_req.wdata = in_d.entry_value;
        if (load) begin
            tbl_req.tsel = in_d.table_select;
            tbl_req.row  = in_d.load_lead;
            tbl_req.col  = in_d.load_trail;
        end else begin
            tbl_req.tsel = r_direction;
            tbl_req.row  = r_held_lead;
            tbl_req.col  = in_d.in_byte;
        end
    end

    dbcs_tbl #(
        .TW(TW),
        .RW(RW),
        .CW(CW)
    ) u_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tbl_req),
        .o_rd_data  (rd_data),
        .o_clr_done (clr_done)
    );

    always_comb begin
        n_lead_pending = r_lead_pending;
        if (conv) begin
            n_lead_pending = r_lead_pending ? 1'b0 : is_lead;
        end
    end

    always_comb begin
        n_b_valid = r_b_valid;
        if (b_load) begin
            n_b_valid = 1'b1;
        end else if (b_move) begin
            n_b_valid = 1'b0;
        end
    end

    // results of the item in the read stage
    assign code = r_b_oor ? 16'd0 : rd_data;

    always_comb begin
        res_b0  = 8'd0;
        res_b1  = 8'd0;
        res_two = 1'b1;
        res_eos = 1'b0;
        unique case (r_b_kind)
            KIND_PAIR: begin
                if (code != 16'd0) begin
                    res_b0 = code[7:0];
                    res_b1 = code[15:8];
                end else begin
                    res_b0 = QMARK;
                    res_b1 = QMARK;
                end
            end
            KIND_ZTRL: begin
                res_b0  = QMARK;
                res_eos = 1'b1;
            end
            KIND_END: begin
                res_two = r_b_uni;
                res_eos = 1'b1;
            end
            KIND_ASCII: begin
                res_b0  = r_b_byte;
                res_two = r_b_uni;
            end
            default: begin
                res_two = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_sel   = r_o_sel;
        if (b_move) begin
            n_o_valid = 1'b1;
            n_o_sel   = 1'b0;
        end else if (o_done) begin
            n_o_valid = 1'b0;
            n_o_sel   = 1'b0;
        end else if (o_xfer) begin
            n_o_sel   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction    <= 2'd0;
            r_lead_pending <= 1'b0;
            r_held_lead    <= 7'd0;
            r_b_valid      <= 1'b0;
            r_o_valid      <= 1'b0;
            r_o_sel        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_direction <= i_cfg_wdata;
            end
            if (is_lead) begin
                r_held_lead <= in_d.in_byte[6:0];
            end
            r_lead_pending <= n_lead_pending;
            r_b_valid      <= n_b_valid;
            r_o_valid      <= n_o_valid;
            r_o_sel        <= n_o_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_kind <= b_kind;
            r_b_byte <= in_d.in_byte;
            r_b_uni  <= (r_direction >= DIR_UNI_FIRST);
            r_b_oor  <= rd_oor;
        end
        if (b_move) begin
            r_o_b0  <= res_b0;
            r_o_b1  <= res_b1;
            r_o_two <= res_two;
            r_o_eos <= res_eos;
        end
    end

    assign o_out.valid              = r_o_valid;
    assign o_out.data.out_byte      = r_o_sel ? r_o_b1 : r_o_b0;
    assign o_out.data.last          = !r_o_two || r_o_sel;
    assign o_out.data.end_of_string = r_o_eos && (!r_o_two || r_o_sel);

    // second byte only exists for two-result items
    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_sel |-> r_o_two)
        else $error("second result shown for a one-result item");

    // a first result is always followed straight away by its second
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.data.last |=> o_out.valid && r_o_sel)
        else $error("second result of an item missing");

    // no table access from items before the clearing sweep has finished
    a_no_acc_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clr_done |-> !tbl_req.re && !tbl_req.we)
        else $error("table accessed during clearing sweep");

    // a waiting read-stage item keeps its kind until it moves on
    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !o_free |=> r_b_valid && $stable(r_b_kind))
        else $error("read stage item lost while output busy");

endmodule

@@ tb/tb_dbcs_table_charset_converter.sv @@
// Self-checking testbench for dbcs_table_charset_converter: table loads and byte
// conversion in all four directions, checked against a built-in charset tracker.
// Depends on dbcs_pkg and dbcs_if (dbcs_in_if, dbcs_out_if) from the RTL.
module tb_dbcs_table_charset_converter;
    import dbcs_pkg::*;

    localparam logic       MODE_LOAD    = 1'b0;
    localparam logic       MODE_CONVERT = 1'b1;
    localparam logic [1:0] DIR_BIG5_GBK = 2'd0;
    localparam logic [1:0] DIR_GBK_BIG5 = 2'd1;
    localparam logic [1:0] DIR_BIG5_UNI = 2'd2;
    localparam logic [1:0] DIR_GBK_UNI  = 2'd3;

    localparam int RUN_LIMIT     = 1_000_000;
    localparam int TOTAL_ITEMS   = 950;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_IDLE      = 13;

    // Tracks the tables, direction and held lead byte; holds the bytes still owed.
    class dbcs_conv_tracker;
        logic [15:0] code_store [int unsigned];
        logic [1:0]  direction;
        logic        lead_held;
        logic [6:0]  lead_row;
        t_out_item   expected_bytes[$];
        int          errors;

        function new();
            direction = DIR_BIG5_GBK;
            lead_held = 1'b0;
            lead_row  = '0;
            errors    = 0;
        endfunction

        function void owe(logic [7:0] b, logic eos, logic lst);
            t_out_item r;
            r.out_byte      = b;
            r.end_of_string = eos;
            r.last          = lst;
            expected_bytes.push_back(r);
        endfunction

        function void note_transfer(t_in_item it);
            logic        unicode;
            logic [15:0] code;
            int unsigned key;
            unicode = (direction >= DIR_UNI_FIRST);
            if (it.mode == MODE_LOAD) begin
                key = {15'd0, it.table_select, it.load_lead, it.load_trail};
                code_store[key] = it.entry_value;
                return;
            end
            if (lead_held) begin
                lead_held = 1'b0;
                if (it.in_byte == 8'h00) begin
                    owe(QMARK, 1'b0, 1'b0);
                    owe(8'h00, 1'b1, 1'b1);
                end else begin
                    key  = {15'd0, direction, lead_row, it.in_byte};
                    code = code_store.exists(key) ? code_store[key] : 16'h0000;
                    if (code != 16'h0000) begin
                        owe(code[7:0], 1'b0, 1'b0);
                        owe(code[15:8], 1'b0, 1'b1);
                    end else begin
                        owe(QMARK, 1'b0, 1'b0);
                        owe(QMARK, 1'b0, 1'b1);
                    end
                end
            end else if (it.in_byte == 8'h00) begin
                if (unicode)
                    owe(8'h00, 1'b0, 1'b0);
                owe(8'h00, 1'b1, 1'b1);
            end else if (!it.in_byte[7]) begin
                if (unicode) begin
                    owe(it.in_byte, 1'b0, 1'b0);
                    owe(8'h00, 1'b0, 1'b1);
                end else begin
                    owe(it.in_byte, 1'b0, 1'b1);
                end
            end else begin
                lead_held = 1'b1;
                lead_row  = it.in_byte[6:0];
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected result: out_byte %02h end_of_string %0b last %0b",
                       got.out_byte, got.end_of_string, got.last);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.end_of_string !== want.end_of_string) begin
                $error("end_of_string: expected %0b, got %0b",
                       want.end_of_string, got.end_of_string);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    dbcs_in_if  in_ch ();
    dbcs_out_if out_ch ();

    dbcs_table_charset_converter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    dbcs_conv_tracker tracker;
    bit               in_calm;
    bit               out_calm;
    int               cycle_count;
    logic [7:0]       lead_pool [8];
    logic [7:0]       trail_pool [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Every task below is entered and left at a rising edge.
    task automatic send_item(t_in_item it);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.note_transfer(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_item it;
        it.mode         = MODE_CONVERT;
        it.in_byte      = b;
        it.table_select = 2'($urandom);
        it.load_lead    = 7'($urandom);
        it.load_trail   = 8'($urandom);
        it.entry_value  = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_load(logic [1:0] ts, logic [6:0] row, logic [7:0] col,
                             logic [15:0] val);
        t_in_item it;
        it.mode         = MODE_LOAD;
        it.in_byte      = 8'($urandom);
        it.table_select = ts;
        it.load_lead    = row;
        it.load_trail   = col;
        it.entry_value  = val;
        send_item(it);
    endtask

    task automatic send_noise();
        t_in_item it;
        it.mode         = 1'($urandom_range(0, 1));
        it.in_byte      = 8'($urandom);
        it.table_select = 2'($urandom);
        it.load_lead    = 7'($urandom);
        it.load_trail   = 8'($urandom);
        it.entry_value  = 16'($urandom);
        send_item(it);
    endtask

    // Drain all owed bytes, then allow for loads or lead bytes still in the pipe.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(logic [1:0] d);
        i_cfg_wdata <= d;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.direction = d;
    endtask

    // Result side: random stall before each transfer, none while out_calm is set
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            tracker.check_result(out_ch.data);
        end
    end

    initial begin
        int sent;
        int phase;
        int plen;
        int n;
        int pick;
        int r;
        logic [1:0] ts;

        tracker     = new();
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n     <= 1'b1;

        // Directed part; the block only takes items once its table sweep is done
        write_direction(DIR_BIG5_GBK);
        send_load(DIR_BIG5_GBK, 7'h01, 8'h40, 16'hA4A1);
        send_load(DIR_BIG5_GBK, 7'h7F, 8'hFF, 16'hFFFF);
        send_load(DIR_BIG5_UNI, 7'h01, 8'h40, 16'h4E00);
        send_load(DIR_GBK_UNI, 7'h00, 8'h00, 16'h0001);
        send_load(DIR_GBK_BIG5, 7'h00, 8'h01, 16'h00A1);
        send_byte(8'h41);
        send_byte(8'h81);               // mapped pair
        send_byte(8'h40);
        send_byte(8'hFF);               // top corner of the table
        send_byte(8'hFF);
        send_byte(8'h80);               // trail below 128, unmapped
        send_byte(8'h7F);
        send_byte(8'h81);               // zero trail ends the string
        send_byte(8'h00);
        send_byte(8'h00);               // plain terminator
        send_byte(8'h7F);
        settle();
        write_direction(DIR_BIG5_UNI);
        send_byte(8'h81);
        send_byte(8'h40);
        send_byte(8'h41);
        send_byte(8'h00);               // two-byte terminator
        settle();
        write_direction(DIR_GBK_BIG5);
        send_byte(8'h80);
        send_byte(8'h01);               // entry with a zero high byte
        send_byte(8'h00);

        lead_pool[0] = 8'h80;
        lead_pool[1] = 8'hFF;
        lead_pool[2] = 8'h81;
        lead_pool[3] = 8'hFE;
        for (int i = 4; i < 8; i++)
            lead_pool[i] = 8'h80 | 8'($urandom);
        trail_pool[0] = 8'h40;
        trail_pool[1] = 8'hFE;
        trail_pool[2] = 8'hA0;
        trail_pool[3] = 8'h81;
        trail_pool[4] = 8'hFF;
        trail_pool[5] = 8'h01;
        for (int i = 6; i < 8; i++)
            trail_pool[i] = 8'($urandom_range(1, 255));

        // Random phases: a small key set so that loads and pairs meet often
        sent  = 0;
        phase = 0;
        while (sent < TOTAL_ITEMS) begin
            settle();
            write_direction(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            plen = $urandom_range(15, 60);
            n = 0;
            while (n < plen) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    ts = ($urandom_range(0, 2) == 0) ? 2'($urandom) : tracker.direction;
                    send_load(ts, lead_pool[$urandom_range(0, 7)][6:0],
                              trail_pool[$urandom_range(0, 7)],
                              ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
                    n++;
                end else if (pick < 20) begin
                    send_noise();
                    n++;
                end else if (pick < 55) begin
                    send_byte(lead_pool[$urandom_range(0, 7)]);
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        send_byte(8'h00);
                    else if (r < 3)
                        send_byte(8'($urandom_range(1, 255)));
                    else
                        send_byte(trail_pool[$urandom_range(0, 7)]);
                    n += 2;
                end else if (pick < 85) begin
                    send_byte(8'($urandom_range(1, 127)));
                    n++;
                end else begin
                    send_byte(8'h00);
                    n++;
                end
            end
            sent += n;
            phase++;
        end

        settle();
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
